// ===== src/bsp_pkg.sv =====
// Package for the B-spline curve point evaluator.
// Holds beat types, operation and register codes, controller states, datapath
// commands and the saturation helper. Depends on nothing.
package bsp_pkg;

  // Default sizes. The top level hands these down as parameters.
  localparam int MAX_CTRL_POINTS_DEF = 64;
  localparam int MAX_DEGREE_DEF      = 7;
  localparam int KNOT_DEPTH_DEF      = 72;

  // Operation codes of an input beat.
  localparam logic [1:0] OPC_LOAD_KNOT = 2'd0;
  localparam logic [1:0] OPC_LOAD_CTRL = 2'd1;
  localparam logic [1:0] OPC_EVAL      = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_DEGREE = 1'b0;
  localparam logic CFG_LAST   = 1'b1;

  // Fixed-point constants. Basis values are Q1.30.
  localparam logic signed [31:0] BASIS_ONE  = 32'sh4000_0000;
  localparam int                 BASIS_FRAC = 30;
  localparam logic [1:0]         COORD_LAST = 2'd2;

  // Serial divider sizes: dividend magnitude below 2^63, divisor up to 2^32.
  localparam int DVD_W     = 63;
  localparam int DVS_W     = 33;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(DVD_W - 1);

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  typedef struct packed {
    logic [1:0]         operation;
    logic [6:0]         entry_index;
    logic [31:0]        knot_value;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [31:0]        param_u;
  } in_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [5:0]         span_found;
    logic               divide_fault;
  } out_t;

  // One datapath operation per cycle.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD_KNOT,
    OP_LOAD_CTRL,
    OP_EVAL_START,
    OP_RD_TOP,
    OP_TOP_CHK,
    OP_SRCH_FIRST,
    OP_SRCH_STEP,
    OP_BASIS_INIT,
    OP_RD_LEFT,
    OP_RD_RIGHT,
    OP_SET_RIGHT,
    OP_MUL1,
    OP_DIV_START,
    OP_ST1,
    OP_MUL2,
    OP_ST2,
    OP_PT_INIT,
    OP_PT_RD,
    OP_PT_MUL,
    OP_PT_ACC,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic top_hit;
    logic srch_done;
    logic p_zero;
    logic div_zero;
    logic div_busy;
    logic r_last;
    logic j_last;
    logic c_last;
    logic k_last;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_TOP,
    ST_TOP_CHK,
    ST_SRCH_FIRST,
    ST_SRCH,
    ST_BASIS_INIT,
    ST_RD_LEFT,
    ST_RD_RIGHT,
    ST_SET_RIGHT,
    ST_MUL1,
    ST_DIV1,
    ST_WAIT1,
    ST_ST1,
    ST_MUL2,
    ST_DIV2,
    ST_WAIT2,
    ST_ST2,
    ST_PT_INIT,
    ST_PT_RD,
    ST_PT_MUL,
    ST_PT_ACC,
    ST_FINISH
  } ctl_state_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > SAT_MAX) return 32'sh7FFF_FFFF;
    if (v < SAT_MIN) return 32'sh8000_0000;
    return 32'(v);
  endfunction

endpackage

// ===== src/bsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the knot and control point stores. No dependencies.
module bsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/bsp_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Takes a 63-bit dividend and a 33-bit divisor. Uses bsp_pkg.
module bsp_div import bsp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             busy
);

  logic [DVS_W-1:0]     rem;
  logic [DVD_W-1:0]     qreg;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVS_W:0]       trial;
  logic                 ge;

  // Shift the next dividend bit into the partial remainder and compare.
  assign trial = {rem, qreg[DVD_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      qreg <= dividend;
      rem  <= '0;
      cnt  <= DIV_LAST_STEP;
    end else if (busy) begin
      rem  <= ge ? DVS_W'(trial - {1'b0, divisor}) : DVS_W'(trial);
      qreg <= {qreg[DVD_W-2:0], ge};
      cnt  <= cnt - DIV_CNT_W'(1);
    end
  end

  assign quotient = qreg;

endmodule

// ===== src/bsp_datapath.sv =====
// Datapath of the B-spline evaluator: configuration registers, knot and
// control point stores, span search, basis recurrence and point sum.
// Uses bsp_pkg, bsp_ram and bsp_div.
module bsp_datapath import bsp_pkg::*; #(
  parameter int MAX_CTRL_POINTS = MAX_CTRL_POINTS_DEF,
  parameter int MAX_DEGREE      = MAX_DEGREE_DEF,
  parameter int KNOT_DEPTH      = KNOT_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic       cfg_index,
  input  logic [5:0] cfg_data,
  input  in_t        in_item,
  input  dp_cmd_t    cmd,
  output dp_stat_t   stat,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_item
);

  localparam int NW = $clog2(MAX_CTRL_POINTS);
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int IW = $clog2(MAX_CTRL_POINTS + MAX_DEGREE + 1);
  localparam int KW = $clog2(KNOT_DEPTH);
  localparam int NB = MAX_DEGREE + 1;

  logic [2:0]         cfg_deg;
  logic [5:0]         cfg_last;
  logic [31:0]        u;
  logic [NW-1:0]      n;
  logic [DW-1:0]      p;
  logic [NW-1:0]      span;
  logic [NW-1:0]      i;
  logic               lo_ok;
  logic [DW-1:0]      j;
  logic [DW-1:0]      r;
  logic [1:0]         c;
  logic signed [31:0] saved;
  logic signed [31:0] basis [NB];
  logic signed [31:0] left  [NB];
  logic signed [31:0] right [NB];
  logic signed [63:0] prod;
  logic signed [31:0] nb_hold;
  logic signed [31:0] lft_hold;
  logic signed [32:0] div_hold;
  logic signed [39:0] acc [3];
  logic               fault;
  logic               k_oor;

  int                 n_int;
  int                 p_int;
  logic [IW-1:0]      kaddr;
  logic [31:0]        k_rdata;
  logic [31:0]        kdata;
  logic [95:0]        c_rdata;
  logic [NW-1:0]      caddr;
  logic signed [31:0] coord_sel;
  logic signed [31:0] ma;
  logic signed [31:0] mb;
  logic signed [63:0] mul_out;
  logic signed [63:0] shifted;
  logic signed [32:0] div_sum;
  logic [DVD_W-1:0]   dvd_mag;
  logic [DVS_W-1:0]   dvs_mag;
  logic [DVD_W-1:0]   q_mag;
  logic signed [63:0] q_s;
  logic signed [31:0] q_sat;
  logic signed [31:0] sum1;
  logic               div_busy;
  logic               k_we;
  logic               c_we;

  // Effective last index and degree, clamped to the store sizes.
  always_comb begin
    n_int = int'(cfg_last);
    if (n_int > MAX_CTRL_POINTS - 1) n_int = MAX_CTRL_POINTS - 1;
    p_int = int'(cfg_deg);
    if (p_int > n_int) p_int = n_int;
    if (p_int > MAX_DEGREE) p_int = MAX_DEGREE;
  end

  // Knot read address for each search and recurrence step.
  always_comb begin
    unique case (cmd.op)
      OP_RD_TOP:     kaddr = IW'(n) + IW'(1);
      OP_TOP_CHK:    kaddr = IW'(p);
      OP_SRCH_FIRST: kaddr = IW'(i) + IW'(1);
      OP_SRCH_STEP:  kaddr = IW'(i) + IW'(2);
      OP_RD_LEFT:    kaddr = IW'(span) + IW'(1) - IW'(j);
      OP_RD_RIGHT:   kaddr = IW'(span) + IW'(j);
      default:       kaddr = '0;
    endcase
  end

  assign k_we = (cmd.op == OP_LOAD_KNOT) && (int'(in_item.entry_index) < KNOT_DEPTH);
  assign c_we = (cmd.op == OP_LOAD_CTRL) && (int'(in_item.entry_index) < MAX_CTRL_POINTS);

  bsp_ram #(.WIDTH(32), .DEPTH(KNOT_DEPTH)) u_knot_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (KW'(in_item.entry_index)),
    .wdata (in_item.knot_value),
    .re    (1'b1),
    .raddr (KW'(kaddr)),
    .rdata (k_rdata)
  );

  assign caddr = span - NW'(p) + NW'(r);

  bsp_ram #(.WIDTH(96), .DEPTH(MAX_CTRL_POINTS)) u_ctrl_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (NW'(in_item.entry_index)),
    .wdata ({in_item.coord_x, in_item.coord_y, in_item.coord_z}),
    .re    (cmd.op == OP_PT_RD),
    .raddr (caddr),
    .rdata (c_rdata)
  );

  // A knot read past the store reads as zero.
  assign kdata = k_oor ? 32'd0 : k_rdata;

  always_comb begin
    unique case (c)
      2'd0:    coord_sel = $signed(c_rdata[95:64]);
      2'd1:    coord_sel = $signed(c_rdata[63:32]);
      default: coord_sel = $signed(c_rdata[31:0]);
    endcase
  end

  // The one shared multiplier.
  always_comb begin
    unique case (cmd.op)
      OP_MUL1: begin
        ma = right[r + DW'(1)];
        mb = basis[r];
      end
      OP_MUL2: begin
        ma = lft_hold;
        mb = nb_hold;
      end
      default: begin
        ma = coord_sel;
        mb = basis[r];
      end
    endcase
  end

  assign mul_out = 64'(ma) * 64'(mb);
  assign shifted = prod >>> BASIS_FRAC;
  assign div_sum = 33'(right[r + DW'(1)]) + 33'(left[j - r]);

  // Divide magnitudes and restore the quotient sign.
  assign dvd_mag = prod[63] ? DVD_W'(-prod) : DVD_W'(prod);
  assign dvs_mag = div_hold[32] ? DVS_W'(-div_hold) : DVS_W'(div_hold);

  bsp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_DIV_START),
    .dividend (dvd_mag),
    .divisor  (dvs_mag),
    .quotient (q_mag),
    .busy     (div_busy)
  );

  assign q_s   = (prod[63] ^ div_hold[32]) ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  assign q_sat = sat32(66'(q_s));
  assign sum1  = sat32(66'(saved) + 66'(q_s));

  // Status for the controller.
  always_comb begin
    stat.top_hit   = u >= kdata;
    stat.srch_done = (lo_ok && (u < kdata)) || (i == n);
    stat.p_zero    = p == '0;
    stat.div_zero  = div_sum == '0;
    stat.div_busy  = div_busy;
    stat.r_last    = r == j - DW'(1);
    stat.j_last    = j == p;
    stat.c_last    = c == COORD_LAST;
    stat.k_last    = r == p;
    stat.out_free  = !out_valid || !out_stall;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_deg  <= 3'd3;
      cfg_last <= 6'd3;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEGREE: cfg_deg  <= cfg_data[2:0];
        CFG_LAST:   cfg_last <= cfg_data;
      endcase
    end
  end

  // Output beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_FINISH) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Working registers, stepped by the controller's command.
  always_ff @(posedge clk) begin
    k_oor <= !(int'(kaddr) < KNOT_DEPTH);
    unique case (cmd.op)
      OP_EVAL_START: begin
        u     <= in_item.param_u;
        n     <= NW'(n_int);
        p     <= DW'(p_int);
        fault <= 1'b0;
      end
      OP_TOP_CHK: begin
        span <= n;
        i    <= NW'(p);
      end
      OP_SRCH_FIRST: begin
        lo_ok <= kdata <= u;
      end
      OP_SRCH_STEP: begin
        span  <= (lo_ok && (u < kdata)) ? i : NW'(p);
        i     <= i + NW'(1);
        lo_ok <= kdata <= u;
      end
      OP_BASIS_INIT: begin
        basis[0] <= BASIS_ONE;
        j        <= DW'(1);
      end
      OP_RD_RIGHT: begin
        left[j] <= sat32(66'($signed({1'b0, u})) - 66'($signed({1'b0, kdata})));
      end
      OP_SET_RIGHT: begin
        right[j] <= sat32(66'($signed({1'b0, kdata})) - 66'($signed({1'b0, u})));
        r        <= '0;
        saved    <= '0;
      end
      OP_MUL1: begin
        prod     <= mul_out;
        nb_hold  <= basis[r];
        lft_hold <= left[j - r];
        div_hold <= div_sum;
        fault    <= div_sum == '0;
      end
      OP_ST1: begin
        basis[r] <= sum1;
      end
      OP_MUL2: begin
        prod <= mul_out;
      end
      OP_ST2: begin
        saved <= q_sat;
        if (r == j - DW'(1)) begin
          basis[j] <= q_sat;
          j        <= j + DW'(1);
        end else begin
          r <= r + DW'(1);
        end
      end
      OP_PT_INIT: begin
        r      <= '0;
        c      <= '0;
        acc[0] <= '0;
        acc[1] <= '0;
        acc[2] <= '0;
      end
      OP_PT_RD: begin
        c <= '0;
      end
      OP_PT_MUL: begin
        prod <= mul_out;
      end
      OP_PT_ACC: begin
        acc[c] <= acc[c] + 40'(shifted);
        if (c == COORD_LAST) begin
          c <= '0;
          r <= r + DW'(1);
        end else begin
          c <= c + 2'd1;
        end
      end
      OP_FINISH: begin
        out_item.point_x      <= fault ? 32'sd0 : sat32(66'(acc[0]));
        out_item.point_y      <= fault ? 32'sd0 : sat32(66'(acc[1]));
        out_item.point_z      <= fault ? 32'sd0 : sat32(66'(acc[2]));
        out_item.span_found   <= 6'(span);
        out_item.divide_fault <= fault;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/bsp_ctrl.sv =====
// Controller state machine of the B-spline evaluator.
// Sequences search, recurrence and point sum through datapath commands.
// Uses bsp_pkg.
module bsp_ctrl import bsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_operation,
  output logic       in_stall,
  output dp_cmd_t    cmd,
  input  dp_stat_t   stat
);

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_operation == OPC_EVAL) state_next = ST_RD_TOP;
      end
      ST_RD_TOP:     state_next = ST_TOP_CHK;
      ST_TOP_CHK:    state_next = stat.top_hit ? ST_BASIS_INIT : ST_SRCH_FIRST;
      ST_SRCH_FIRST: state_next = ST_SRCH;
      ST_SRCH: begin
        if (stat.srch_done) state_next = ST_BASIS_INIT;
      end
      ST_BASIS_INIT: state_next = stat.p_zero ? ST_PT_INIT : ST_RD_LEFT;
      ST_RD_LEFT:    state_next = ST_RD_RIGHT;
      ST_RD_RIGHT:   state_next = ST_SET_RIGHT;
      ST_SET_RIGHT:  state_next = ST_MUL1;
      ST_MUL1:       state_next = stat.div_zero ? ST_FINISH : ST_DIV1;
      ST_DIV1:       state_next = ST_WAIT1;
      ST_WAIT1: begin
        if (!stat.div_busy) state_next = ST_ST1;
      end
      ST_ST1:        state_next = ST_MUL2;
      ST_MUL2:       state_next = ST_DIV2;
      ST_DIV2:       state_next = ST_WAIT2;
      ST_WAIT2: begin
        if (!stat.div_busy) state_next = ST_ST2;
      end
      ST_ST2: begin
        priority if (stat.r_last && stat.j_last) state_next = ST_PT_INIT;
        else if (stat.r_last)                    state_next = ST_RD_LEFT;
        else                                     state_next = ST_MUL1;
      end
      ST_PT_INIT:    state_next = ST_PT_RD;
      ST_PT_RD:      state_next = ST_PT_MUL;
      ST_PT_MUL:     state_next = ST_PT_ACC;
      ST_PT_ACC: begin
        priority if (!stat.c_last) state_next = ST_PT_MUL;
        else if (stat.k_last)      state_next = ST_FINISH;
        else                       state_next = ST_PT_RD;
      end
      ST_FINISH: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default:       state_next = ST_IDLE;
    endcase
  end

  // Command for the datapath and input stall.
  always_comb begin
    in_stall = state != ST_IDLE;
    cmd.op   = OP_NOP;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_operation)
            OPC_LOAD_KNOT: cmd.op = OP_LOAD_KNOT;
            OPC_LOAD_CTRL: cmd.op = OP_LOAD_CTRL;
            OPC_EVAL:      cmd.op = OP_EVAL_START;
            default:       cmd.op = OP_NOP;
          endcase
        end
      end
      ST_RD_TOP:     cmd.op = OP_RD_TOP;
      ST_TOP_CHK:    cmd.op = OP_TOP_CHK;
      ST_SRCH_FIRST: cmd.op = OP_SRCH_FIRST;
      ST_SRCH:       cmd.op = OP_SRCH_STEP;
      ST_BASIS_INIT: cmd.op = OP_BASIS_INIT;
      ST_RD_LEFT:    cmd.op = OP_RD_LEFT;
      ST_RD_RIGHT:   cmd.op = OP_RD_RIGHT;
      ST_SET_RIGHT:  cmd.op = OP_SET_RIGHT;
      ST_MUL1:       cmd.op = OP_MUL1;
      ST_DIV1:       cmd.op = OP_DIV_START;
      ST_ST1:        cmd.op = OP_ST1;
      ST_MUL2:       cmd.op = OP_MUL2;
      ST_DIV2:       cmd.op = OP_DIV_START;
      ST_ST2:        cmd.op = OP_ST2;
      ST_PT_INIT:    cmd.op = OP_PT_INIT;
      ST_PT_RD:      cmd.op = OP_PT_RD;
      ST_PT_MUL:     cmd.op = OP_PT_MUL;
      ST_PT_ACC:     cmd.op = OP_PT_ACC;
      ST_FINISH:     cmd.op = stat.out_free ? OP_FINISH : OP_NOP;
      default:       cmd.op = OP_NOP;
    endcase
  end

endmodule

// ===== src/bspline_curve_point_eval_unit.sv =====
// B-spline curve point evaluator, top level.
// Uses bsp_pkg, bsp_ctrl and bsp_datapath.
//
// Input beats arrive on in_valid/in_stall/in_item. A knot load or control
// point load is taken in idle and gives no result. An evaluate beat gives
// one result beat on out_valid/out_stall/out_item: the point, the span used
// and a flag for a zero divisor (point then reads zero).
// The block works on one evaluation at a time and holds in_stall high until
// it is back in idle. Each basis term needs two quotients from the 63-step
// serial divider. A finished result waits in the output register while
// out_stall is high; the block accepts a new beat once it has stored the
// result there. Configuration writes on cfg_valid/cfg_index/cfg_data are
// always ready; the user must make them while the block is idle, which the
// block itself does not enforce. Synchronous reset sets degree and last
// index to 3 and empties the output; the stores keep no reset value.
module bspline_curve_point_eval_unit import bsp_pkg::*; #(
  parameter int MAX_CTRL_POINTS = MAX_CTRL_POINTS_DEF,
  parameter int MAX_DEGREE      = MAX_DEGREE_DEF,
  parameter int KNOT_DEPTH      = KNOT_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [5:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  bsp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_operation (in_item.operation),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .stat         (stat)
  );

  bsp_datapath #(
    .MAX_CTRL_POINTS (MAX_CTRL_POINTS),
    .MAX_DEGREE      (MAX_DEGREE),
    .KNOT_DEPTH      (KNOT_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== test/bspline_curve_point_eval_unit_tb.sv =====
// Testbench for the B-spline curve point evaluator: loads, evaluations and
// register settings, each result checked against a built-in predictor.
// Depends on bsp_pkg and the bspline_curve_point_eval_unit RTL.
module bspline_curve_point_eval_unit_tb;
  import bsp_pkg::*;

  localparam logic [1:0] OPC_UNUSED = 2'd3;
  localparam int KNOTS = 72;
  localparam int CTRLS = 64;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  in_t        in_item;
  logic       out_valid;
  logic       out_stall;
  out_t       out_item;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [5:0] cfg_data;

  bspline_curve_point_eval_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: register copies and store copies, updated on accepted beats.
  logic [2:0]         degree_reg;
  logic [5:0]         last_reg;
  logic [31:0]        knot_mem [KNOTS];
  logic signed [31:0] ctrl_mem [CTRLS][3];

  // Knot values as planned on the stimulus side, used to aim parameters.
  logic [31:0] plan_knots [KNOTS];

  in_t  pending_beats [$];
  out_t expected_points [$];
  int   fail_count;
  int   in_gap;
  int   out_gap;
  bit   calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint knot_at(int idx);
    if (idx >= KNOTS) return 0;
    return longint'({32'd0, knot_mem[idx]});
  endfunction

  // Span search, Cox-de Boor basis and weighted sum of control points.
  function automatic out_t eval_point(logic [31:0] u32);
    out_t   res;
    int     n, p, span, ci;
    longint u, saved, rgt, lft, dvs, nb;
    longint basis [8];
    longint ldiff [8];
    longint rdiff [8];
    longint acc [3];
    bit     fault;
    n = last_reg;
    p = degree_reg;
    if (p > n) p = n;
    if (p > 7) p = 7;
    u = longint'({32'd0, u32});
    span = -1;
    if (u >= knot_at(n + 1)) span = n;
    else begin
      for (int i = p; i <= n; i++) begin
        if (span < 0 && knot_at(i) <= u && u < knot_at(i + 1)) span = i;
      end
      if (span < 0) span = p;
    end
    fault = 1'b0;
    basis[0] = 64'sd1 << 30;
    for (int j = 1; j <= p && !fault; j++) begin
      saved = 0;
      ldiff[j] = clip32(u - knot_at(span + 1 - j));
      rdiff[j] = clip32(knot_at(span + j) - u);
      for (int r = 0; r < j && !fault; r++) begin
        rgt = rdiff[r + 1];
        lft = ldiff[j - r];
        dvs = rgt + lft;
        nb  = basis[r];
        if (dvs == 0) fault = 1'b1;
        else begin
          basis[r] = clip32(saved + (rgt * nb) / dvs);
          saved = clip32((lft * nb) / dvs);
        end
      end
      basis[j] = saved;
    end
    res.span_found = 6'(span);
    res.divide_fault = fault;
    acc[0] = 0; acc[1] = 0; acc[2] = 0;
    if (!fault) begin
      for (int k = 0; k <= p; k++) begin
        ci = span - p + k;
        if (ci < CTRLS) begin
          for (int c = 0; c < 3; c++)
            acc[c] += (longint'(ctrl_mem[ci][c]) * basis[k]) >>> 30;
        end
      end
    end
    res.point_x = 32'(clip32(acc[0]));
    res.point_y = 32'(clip32(acc[1]));
    res.point_z = 32'(clip32(acc[2]));
    return res;
  endfunction

  // Apply one accepted input beat to the predictor.
  function automatic void absorb_beat(in_t b);
    case (b.operation)
      OPC_LOAD_KNOT: begin
        if (b.entry_index < KNOTS) knot_mem[b.entry_index] = b.knot_value;
      end
      OPC_LOAD_CTRL: begin
        if (b.entry_index < CTRLS) begin
          ctrl_mem[b.entry_index][0] = b.coord_x;
          ctrl_mem[b.entry_index][1] = b.coord_y;
          ctrl_mem[b.entry_index][2] = b.coord_z;
        end
      end
      OPC_EVAL: expected_points.insert(expected_points.size(), eval_point(b.param_u));
      default: ;
    endcase
  endfunction

  // Gap length: mostly none or short, sometimes long, none at all when calm.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Input driver: presents queued beats, idles between them at random.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) absorb_beat(in_item);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          in_item <= pending_beats.pop_front();
          in_valid <= 1'b1;
          in_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: stalls at random and checks each accepted beat.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, out_item);
          fail_count++;
        end else begin
          out_t want;
          want = expected_points.pop_front();
          if (want.point_x !== out_item.point_x) begin
            $display("%0t: point_x expected %h actual %h", $time, want.point_x,
                     out_item.point_x);
            fail_count++;
          end
          if (want.point_y !== out_item.point_y) begin
            $display("%0t: point_y expected %h actual %h", $time, want.point_y,
                     out_item.point_y);
            fail_count++;
          end
          if (want.point_z !== out_item.point_z) begin
            $display("%0t: point_z expected %h actual %h", $time, want.point_z,
                     out_item.point_z);
            fail_count++;
          end
          if (want.span_found !== out_item.span_found) begin
            $display("%0t: span_found expected %0d actual %0d", $time,
                     want.span_found, out_item.span_found);
            fail_count++;
          end
          if (want.divide_fault !== out_item.divide_fault) begin
            $display("%0t: divide_fault expected %b actual %b", $time,
                     want.divide_fault, out_item.divide_fault);
            fail_count++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_gap <= pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_t noise_beat(logic [1:0] op, int idx);
    in_t b;
    b.operation = op;
    b.entry_index = 7'(idx);
    b.knot_value = $urandom();
    b.coord_x = $urandom();
    b.coord_y = $urandom();
    b.coord_z = $urandom();
    b.param_u = $urandom();
    return b;
  endfunction

  task automatic add_knot(int idx, logic [31:0] val);
    in_t b;
    b = noise_beat(OPC_LOAD_KNOT, idx);
    b.knot_value = val;
    if (idx < KNOTS) plan_knots[idx] = val;
    pending_beats.insert(pending_beats.size(), b);
  endtask

  task automatic add_ctrl(int idx);
    pending_beats.insert(pending_beats.size(), noise_beat(OPC_LOAD_CTRL, idx));
  endtask

  task automatic add_ctrl_fixed(int idx, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_t b;
    b = noise_beat(OPC_LOAD_CTRL, idx);
    b.coord_x = x;
    b.coord_y = y;
    b.coord_z = z;
    pending_beats.insert(pending_beats.size(), b);
  endtask

  task automatic add_eval(logic [31:0] u);
    in_t b;
    b = noise_beat(OPC_EVAL, $urandom_range(0, 127));
    b.param_u = u;
    pending_beats.insert(pending_beats.size(), b);
  endtask

  // Clamped knot vector for last index n and degree p, sometimes with repeats.
  task automatic add_clamped_knots(int n, int p);
    logic [31:0] k;
    k = 0;
    for (int i = 0; i <= n + p + 1; i++) begin
      if (i > p && i <= n + 1 && $urandom_range(0, 5) != 0)
        k = k + $urandom_range(1 << 18, 1 << 25);
      add_knot(i, k);
    end
  endtask

  // Wait for the block to drain, then let it settle back into idle.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_points.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  // One register write; returns once the write beat has been taken.
  task automatic write_reg(logic idx, logic [5:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == CFG_DEGREE) degree_reg = val[2:0];
    else last_reg = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Directed and random stimulus over several register settings.
  initial begin
    int degs [8] = '{1, 7, 2, 4, 7, 1, 5, 3};
    int lasts [8] = '{1, 63, 20, 9, 2, 63, 5, 3};
    int evals [8] = '{110, 18, 90, 40, 60, 90, 28, 60};
    int n, p, r;
    logic [31:0] lo, hi, k;
    fail_count = 0;
    calm = 1'b0;
    degree_reg = 3'd3;
    last_reg = 6'd3;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_DEGREE;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Fill both stores so that no read ever touches an unwritten entry.
    k = 0;
    for (int i = 0; i < KNOTS; i++) begin
      add_knot(i, k);
      k = k + $urandom_range(1 << 20, 1 << 24);
    end
    for (int i = 0; i < CTRLS; i++) add_ctrl(i);

    // Directed part under the reset setting: degree 3, last index 3.
    add_clamped_knots(3, 3);
    add_ctrl_fixed(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    add_ctrl_fixed(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    add_eval(32'h0);
    add_eval(32'hFFFF_FFFF);
    add_eval(plan_knots[4]);
    add_eval(plan_knots[4] - 1);
    add_knot(72, 32'hFFFF_FFFF);
    add_ctrl(127);
    pending_beats.insert(pending_beats.size(), noise_beat(OPC_UNUSED, 5));
    // Parameter below the first span.
    add_knot(3, 32'h0100_0000);
    add_eval(32'h0000_1000);
    // Equal knots give a zero divisor.
    for (int i = 0; i < 8; i++) add_knot(i, 32'hFFFF_FFFF);
    add_eval(32'hFFFF_FFFF);
    add_eval(32'h0);
    add_clamped_knots(3, 3);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_DEGREE, 6'(degs[ph]));
      write_reg(CFG_LAST, 6'(lasts[ph]));
      calm = (ph % 3 == 2);
      n = lasts[ph];
      p = (degs[ph] < n) ? degs[ph] : n;
      add_clamped_knots(n, p);
      for (int i = 0; i < evals[ph]; i++) begin
        r = $urandom_range(0, 99);
        lo = plan_knots[p];
        hi = plan_knots[n + 1];
        if (r < 65) begin
          add_eval(lo + $urandom_range(0, hi - lo));
        end else if (r < 72) begin
          add_eval(plan_knots[$urandom_range(p, n + 1)]);
        end else if (r < 77) begin
          add_eval($urandom());
        end else if (r < 92) begin
          add_ctrl($urandom_range(0, 99) < 90 ? $urandom_range(0, n) : $urandom_range(64, 127));
        end else if (r < 97) begin
          add_knot($urandom_range(0, 127), $urandom());
        end else begin
          pending_beats.insert(pending_beats.size(),
                               noise_beat(OPC_UNUSED, $urandom_range(0, 127)));
        end
      end
      wait_drained();
    end

    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("PASS bspline_curve_point_eval_unit");
    else $display("FAIL bspline_curve_point_eval_unit");
    $finish;
  end

  // Run limit.
  initial begin
    #40_000_000;
    $display("FAIL bspline_curve_point_eval_unit");
    $finish;
  end

endmodule
